// ----- rtl/dq_pkg.sv -----
// Shared types and codes for the double-ended queue.
// Used by dq_ctrl and double_ended_queue; no dependencies.
`default_nettype none

package dq_pkg;

  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_LIST       = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } state_t;

  // Result descriptor, registered at the same clock edge as the RAM read data it may select
  typedef struct packed {
    logic    valid;
    status_t status;
    logic    from_ram;
    logic    last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/dq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dq_ctrl.sv -----
// Ring controller: head pointer, entry count, list sequencer and RAM access.
// Depends on dq_pkg; drives one dq_ram instance in the top level.
`default_nettype none

module dq_ctrl #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dq_pkg::REQ_W-1:0]     req_type,
  input  logic [dq_pkg::DATA_W-1:0]    value,
  output logic                         busy,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [dq_pkg::DATA_W-1:0]    mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  output dq_pkg::res_t                 res
);

  import dq_pkg::*;

  state_t          state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   ptr, ptr_next;
  logic [CW-1:0]   remain, remain_next;
  res_t            res_next;

  logic            accept;
  logic            full;
  logic            empty;
  logic [AW-1:0]   head_dec;
  logic [AW-1:0]   head_inc;
  logic [AW-1:0]   ptr_inc;
  logic [AW-1:0]   rear_free;
  logic [AW-1:0]   rear_used;

  // Ring index of base + off, wrapped at DEPTH
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign busy   = (state == ST_LIST);
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);

  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign ptr_inc   = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign rear_free = ring_add(head, count);
  assign rear_used = ring_add(head, count - 1'b1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req_type == REQ_LIST && !empty) begin
          state_next = ST_LIST;
        end
      end
      ST_LIST: begin
        if (remain == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = head;
    mem_wdata   = value;
    mem_re      = 1'b0;
    mem_raddr   = head;
    head_next   = head;
    count_next  = count;
    ptr_next    = ptr;
    remain_next = remain;
    res_next    = '{valid: 1'b0, status: STAT_OK, from_ram: 1'b0, last: 1'b0};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_next.last = 1'b1;
          case (req_type)
            REQ_PUSH_FRONT: begin
              res_next.valid = 1'b1;
              if (full) begin
                res_next.status = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = head_dec;
                head_next  = head_dec;
                count_next = count + 1'b1;
              end
            end
            REQ_PUSH_REAR: begin
              res_next.valid = 1'b1;
              if (full) begin
                res_next.status = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = rear_free;
                count_next = count + 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              res_next.valid = 1'b1;
              if (empty) begin
                res_next.status = STAT_UNDERFLOW;
              end else begin
                mem_re            = 1'b1;
                mem_raddr         = head;
                res_next.from_ram = 1'b1;
                head_next         = head_inc;
                count_next        = count - 1'b1;
              end
            end
            REQ_POP_REAR: begin
              res_next.valid = 1'b1;
              if (empty) begin
                res_next.status = STAT_UNDERFLOW;
              end else begin
                mem_re            = 1'b1;
                mem_raddr         = rear_used;
                res_next.from_ram = 1'b1;
                count_next        = count - 1'b1;
              end
            end
            REQ_LIST: begin
              if (empty) begin
                res_next.valid  = 1'b1;
                res_next.status = STAT_EMPTY;
              end else begin
                ptr_next    = head;
                remain_next = count;
              end
            end
            default: begin
              // drop unknown request codes
              res_next.last = 1'b0;
            end
          endcase
        end
      end
      ST_LIST: begin
        // advance through the ring, one entry per cycle
        mem_re            = 1'b1;
        mem_raddr         = ptr;
        res_next.valid    = 1'b1;
        res_next.from_ram = 1'b1;
        res_next.last     = (remain == CW'(1));
        ptr_next          = ptr_inc;
        remain_next       = remain - 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      head   <= '0;
      count  <= '0;
      remain <= '0;
      res    <= '{valid: 1'b0, status: STAT_OK, from_ram: 1'b0, last: 1'b0};
    end else begin
      state  <= state_next;
      head   <= head_next;
      count  <= count_next;
      remain <= remain_next;
      res    <= res_next;
    end
  end

  // List pointer carries no control meaning outside the list state
  always_ff @(posedge clk) begin
    ptr <= ptr_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above ring depth");

  a_list_remain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIST) |-> (remain != '0 && remain <= count))
    else $error("list sequencer out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !full && (req_type == REQ_PUSH_FRONT || req_type == REQ_PUSH_REAR))
      |=> (count == $past(count) + 1'b1))
    else $error("push did not grow the queue");

  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> (res.valid && res.from_ram))
    else $error("RAM read without a matching result");

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// Double-ended queue top level: ring controller plus one entry RAM.
// Depends on dq_pkg, dq_ctrl and dq_ram.
// Push and pop: result in the cycle after the transaction, a new request each cycle while not busy.
// List of N entries: busy while the single RAM read port walks the ring one entry
// per cycle; each result is registered together with its RAM read data.
// Reset empties the queue (head and count cleared); RAM contents are not cleared.
// The receiver cannot stall: each result is shown for one cycle with strobe.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [dq_pkg::REQ_W-1:0]             req_type,
  input  logic signed [dq_pkg::DATA_W-1:0]     value,
  output logic                                 strobe,
  output logic [dq_pkg::STATUS_W-1:0]          status,
  output logic signed [dq_pkg::DATA_W-1:0]     value_res,
  output logic                                 last
);

  import dq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  res_t              res;

  dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .value     (DATA_W'(unsigned'(value))),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  dq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Present the result transaction; select RAM data only for pops and lists
  assign strobe    = res.valid;
  assign status    = res.status;
  assign last      = res.last;
  assign value_res = (res.valid && res.from_ram) ? signed'(mem_rdata) : '0;

  a_last_on_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && !res.from_ram) |-> last)
    else $error("single result without last");

  a_ok_with_data: assert property (@(posedge clk) disable iff (rst)
    (strobe && res.from_ram) |-> (status == STAT_OK))
    else $error("data result with error status");

  a_busy_strobe: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (strobe && last))
    else $error("list ended without a final result");

endmodule

`default_nettype wire
